>>> rtl/assert_macros.svh
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define REW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define REW_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/rew_pkg.sv
package rew_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int THR_W           = 20;
  localparam int SCORE_W         = 22;
  localparam int COL_W           = 10;
  localparam int WIN_LEN         = 7;
  localparam int FILL_W          = 3;
  localparam int REM_W           = 3;
  localparam int MAX_COLS_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam logic [THR_W-1:0] THR_RESET = 20'd48;

  // token kinds travelling down the score pipeline
  localparam logic [1:0] KIND_SCORE  = 2'd0;
  localparam logic [1:0] KIND_FIRST  = 2'd1;
  localparam logic [1:0] KIND_REPEAT = 2'd2;

  // results per token kind
  localparam logic [REM_W-1:0] CNT_SCORE  = 3'd1;
  localparam logic [REM_W-1:0] CNT_FIRST  = 3'd5;
  localparam logic [REM_W-1:0] CNT_REPEAT = 3'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic       row_end;
    logic       frame_end;
  } tok_t;

endpackage

>>> rtl/rew_if.sv
interface rew_in_if;
  logic                         valid;
  logic                         ready;
  logic [rew_pkg::SAMPLE_W-1:0] sample;
  logic                         last_in_row;
  logic                         last_of_frame;

  modport source (output valid, sample, last_in_row, last_of_frame, input ready);
  modport sink   (input valid, sample, last_in_row, last_of_frame, output ready);
endinterface

interface rew_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rew_pkg::SCORE_W-1:0] score;
  logic                               detect;
  logic [rew_pkg::COL_W-1:0]          column;
  logic                               row_end;
  logic                               frame_end;

  modport source (output valid, score, detect, column, row_end, frame_end, input ready);
  modport sink   (input valid, score, detect, column, row_end, frame_end, output ready);
endinterface

interface rew_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [rew_pkg::THR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/rew_cell.sv
module rew_cell #(
  parameter int WIDTH = rew_pkg::SAMPLE_W
) (
  input  logic             clk,
  input  logic             shift,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

>>> rtl/rew_score.sv
module rew_score #(
  parameter int WB = rew_pkg::SAMPLE_W
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               tok_valid,
  input  rew_pkg::tok_t                      tok,
  input  logic [WB-1:0]                      win [rew_pkg::WIN_LEN],
  output logic                               tok_ready,
  output logic                               res_valid,
  output rew_pkg::tok_t                      res_tok,
  output logic signed [rew_pkg::SCORE_W-1:0] res_score,
  input  logic                               res_ready
);

  localparam int SW = rew_pkg::SCORE_W;

  logic                 s2_valid;
  rew_pkg::tok_t        s2_tok;
  logic signed [SW-1:0] rect;
  logic signed [SW-1:0] edgev;
  logic                 s2_go;
  logic                 s3_go;

  logic signed [SW-1:0] sum01, sum23, sum56, r, e;
  logic signed [SW-1:0] rect_next, edge_next, edge_abs;

  // rect = 7R - 3W = 4R - 3(s0+s1+s5+s6), edge = 7E - 3W = 4E - 3(s0+s1+s2+s3)
  always_comb begin
    sum01     = SW'(win[0]) + SW'(win[1]);
    sum23     = SW'(win[2]) + SW'(win[3]);
    sum56     = SW'(win[5]) + SW'(win[6]);
    r         = sum23 + SW'(win[4]);
    e         = sum56 + SW'(win[4]);
    rect_next = (r <<< 2) - SW'(3) * (sum01 + sum56);
    edge_next = (e <<< 2) - SW'(3) * (sum01 + sum23);
    edge_abs  = edgev[SW-1] ? -edgev : edgev;
  end

  assign s3_go     = !res_valid || res_ready;
  assign s2_go     = !s2_valid || s3_go;
  assign tok_ready = s2_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s2_go) begin
        s2_valid <= tok_valid;
      end
      if (s3_go) begin
        res_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s2_tok <= tok;
      rect   <= rect_next;
      edgev  <= edge_next;
    end
    if (s3_go) begin
      res_tok   <= s2_tok;
      res_score <= rect - edge_abs;
    end
  end

endmodule

>>> rtl/rew_emit.sv
module rew_emit #(
  parameter int MAX_COLS = rew_pkg::MAX_COLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [rew_pkg::THR_W-1:0]          thr,
  input  logic                               tok_valid,
  input  rew_pkg::tok_t                      tok,
  input  logic signed [rew_pkg::SCORE_W-1:0] tok_score,
  output logic                               tok_ready,
  rew_out_if.source                          results
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int SW = rew_pkg::SCORE_W;
  localparam int RW = rew_pkg::REM_W;

  logic [RW-1:0]        rem;
  logic                 cur_row_end;
  logic                 cur_frame_end;
  logic signed [SW-1:0] last_score;
  logic [CW-1:0]        col;
  logic                 out_ok;
  logic                 emit;
  logic                 take;
  logic                 final_copy;
  logic [RW-1:0]        cnt;

  assign out_ok     = !results.valid || results.ready;
  assign emit       = (rem != '0) && out_ok;
  assign tok_ready  = (rem == '0) || ((rem == RW'(1)) && out_ok);
  assign take       = tok_valid && tok_ready;
  assign final_copy = rem == RW'(1);

  always_comb begin
    case (tok.kind)
      rew_pkg::KIND_FIRST:  cnt = rew_pkg::CNT_FIRST;
      rew_pkg::KIND_REPEAT: cnt = rew_pkg::CNT_REPEAT;
      default:              cnt = rew_pkg::CNT_SCORE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem           <= '0;
      results.valid <= 1'b0;
      col           <= '0;
      last_score    <= '0;
    end else begin
      if (out_ok) begin
        results.valid <= emit;
      end
      if (emit) begin
        if (final_copy && cur_row_end) begin
          col <= '0;
        end else if (col < CW'(MAX_COLS - 1)) begin
          col <= col + CW'(1);
        end
      end
      if (take) begin
        rem <= cnt;
        if (tok.kind != rew_pkg::KIND_REPEAT) begin
          last_score <= tok_score;
        end
      end else if (emit) begin
        rem <= rem - RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_row_end   <= tok.row_end;
      cur_frame_end <= tok.frame_end;
    end
    if (emit) begin
      results.score     <= last_score;
      results.detect    <= last_score > $signed({2'b00, thr});
      results.column    <= rew_pkg::COL_W'(col);
      results.row_end   <= final_copy && cur_row_end;
      results.frame_end <= final_copy && cur_frame_end;
    end
  end

endmodule

>>> rtl/rect_edge_window_detector.sv
// Rectangular-pulse / edge detector over streamed spectrogram rows.
// samples: one bin per request (sample, last_in_row, last_of_frame);
//   last_of_frame also ends the row.
// results: score = 12 x (rect - |edge|) over a 7-bin window, detect when
//   score > threshold, saturating column, row_end and frame_end marks.
// cfg: 20-bit threshold (x12), always ready, write only while idle.
// Bins flow through a 7-cell shift chain into a two-stage score pipe
// and an output sequencer that issues the results of each bin.
// The first result of a bin passes the token register, both score stages and the output register.
// Throughput: one bin per cycle; the 7th bin of a row gives 5 results,
//   which stalls the input in rows of 10 or more bins. The 3 results
//   of a row's last bin drain while the next row's first 6 bins, which
//   give none, flow in. One result per cycle.
// Bins 1..6 of a row give no result; a row shorter than 7 gives none.
// Reset: threshold 48, fill count and column cleared, no result pending.
// A stalled receiver holds the output register; the pipe fills behind it
// and samples.ready drops until space frees up.
module rect_edge_window_detector #(
  parameter int MAX_COLS    = rew_pkg::MAX_COLS_DEF,
  parameter int SAMPLE_BITS = rew_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rew_in_if.sink     samples,
  rew_out_if.source  results,
  rew_cfg_if.sink    cfg
);

  localparam int WB = (SAMPLE_BITS < rew_pkg::SAMPLE_W) ? SAMPLE_BITS : rew_pkg::SAMPLE_W;
  localparam int FW = rew_pkg::FILL_W;
  localparam int NW = rew_pkg::WIN_LEN;

  logic [rew_pkg::THR_W-1:0] thr;
  logic [FW-1:0]             fill;
  logic [WB-1:0]             win [NW];
  logic                      t1_valid;
  rew_pkg::tok_t             t1_tok;
  logic                      s2_ready;
  logic                      s1_go;
  logic                      acc;
  logic                      rend;
  logic                      full;
  logic                      pre_full;
  logic                      shift;
  logic                      tok_v;
  rew_pkg::tok_t             tok;

  logic                               s3_valid;
  rew_pkg::tok_t                      s3_tok;
  logic signed [rew_pkg::SCORE_W-1:0] s3_score;
  logic                               e_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= rew_pkg::THR_RESET;
    end else if (cfg.valid) begin
      thr <= cfg.data;
    end
  end

  assign s1_go         = !t1_valid || s2_ready;
  assign samples.ready = s1_go;
  assign acc           = samples.valid && s1_go;
  assign rend          = samples.last_in_row || samples.last_of_frame;
  assign full          = fill == FW'(NW);
  assign pre_full      = fill == FW'(NW - 1);
  assign shift         = acc && !(full && rend);

  always_comb begin
    tok       = '0;
    tok_v     = 1'b0;
    if (full && rend) begin
      tok_v         = 1'b1;
      tok.kind      = rew_pkg::KIND_REPEAT;
      tok.row_end   = 1'b1;
      tok.frame_end = samples.last_of_frame;
    end else if (full) begin
      tok_v    = 1'b1;
      tok.kind = rew_pkg::KIND_SCORE;
    end else if (pre_full) begin
      tok_v         = 1'b1;
      tok.kind      = rew_pkg::KIND_FIRST;
      tok.row_end   = rend;
      tok.frame_end = samples.last_of_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      t1_valid <= 1'b0;
    end else begin
      if (acc) begin
        if (rend) begin
          fill <= '0;
        end else if (!full) begin
          fill <= fill + FW'(1);
        end
      end
      if (s1_go) begin
        t1_valid <= acc && tok_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      t1_tok <= tok;
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_cell
    if (i == NW - 1) begin : g_head
      rew_cell #(.WIDTH(WB)) u_cell (
        .clk   (clk),
        .shift (shift),
        .d     (samples.sample[WB-1:0]),
        .q     (win[i])
      );
    end else begin : g_body
      rew_cell #(.WIDTH(WB)) u_cell (
        .clk   (clk),
        .shift (shift),
        .d     (win[i+1]),
        .q     (win[i])
      );
    end
  end

  rew_score #(.WB(WB)) u_score (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (t1_valid),
    .tok       (t1_tok),
    .win       (win),
    .tok_ready (s2_ready),
    .res_valid (s3_valid),
    .res_tok   (s3_tok),
    .res_score (s3_score),
    .res_ready (e_ready)
  );

  rew_emit #(.MAX_COLS(MAX_COLS)) u_emit (
    .clk       (clk),
    .rst       (rst),
    .thr       (thr),
    .tok_valid (s3_valid),
    .tok       (s3_tok),
    .tok_score (s3_score),
    .tok_ready (e_ready),
    .results   (results)
  );

endmodule

>>> rtl/rew_chk.sv
`include "assert_macros.svh"

module rew_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [rew_pkg::SCORE_W-1:0] out_score,
  input logic [rew_pkg::COL_W-1:0]          out_column,
  input logic                               out_row_end,
  input logic                               out_frame_end
);

  logic out_acc;
  assign out_acc = out_valid && out_ready;

  `REW_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_score) && $stable(out_column))
  `REW_ASSERT_IMP(a_frame_row, clk, rst, out_valid && out_frame_end, out_row_end)
  `REW_ASSERT_NXT(a_row_restart, clk, rst, out_acc && out_row_end, !out_valid || out_column == '0)
  `REW_ASSERT_NXT(a_col_step, clk, rst, out_acc && !out_row_end, !out_valid || out_column == $past(out_column) + 1'b1 || out_column == $past(out_column))

endmodule

bind rect_edge_window_detector rew_chk u_rew_chk (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .out_score     (results.score),
  .out_column    (results.column),
  .out_row_end   (results.row_end),
  .out_frame_end (results.frame_end)
);

>>> verif/tb_rect_edge_window_detector.sv
`timescale 1ns / 100ps

module tb_rect_edge_window_detector;

  localparam int THR_MAX      = 786420;
  localparam int MAX_COLS     = rew_pkg::MAX_COLS_DEF;
  localparam int DRAIN_GAP    = 16;
  localparam int HOLD_AT      = 100;
  localparam int HOLD_PENDING = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 60000;

  typedef enum int {
    ROW_NOISE,
    ROW_PULSE,
    ROW_STEP,
    ROW_FAINT
  } row_shape_t;

  typedef struct packed {
    logic [rew_pkg::SAMPLE_W-1:0] sample;
    logic                         last_in_row;
    logic                         last_of_frame;
  } bin_req_t;

  typedef struct packed {
    logic signed [rew_pkg::SCORE_W-1:0] score;
    logic                               detect;
    logic [rew_pkg::COL_W-1:0]          column;
    logic                               row_end;
    logic                               frame_end;
  } det_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         in_valid  = 1'b0;
  logic [rew_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                         in_lir    = 1'b0;
  logic                         in_lof    = 1'b0;
  logic                         out_ready = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic [rew_pkg::THR_W-1:0]    cfg_data  = rew_pkg::THR_RESET;

  rew_in_if  samples_if ();
  rew_out_if results_if ();
  rew_cfg_if cfg_if ();

  assign samples_if.valid         = in_valid;
  assign samples_if.sample        = in_sample;
  assign samples_if.last_in_row   = in_lir;
  assign samples_if.last_of_frame = in_lof;
  assign results_if.ready         = out_ready;
  assign cfg_if.valid             = cfg_valid;
  assign cfg_if.data              = cfg_data;

  rect_edge_window_detector uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bin_req_t    pending_bins[$];
  det_result_t due_results[$];

  int bins_queued = 0;
  int bins_taken  = 0;
  int errors      = 0;
  int cycles      = 0;
  bit idle_on     = 1'b0;

  // window model
  logic [rew_pkg::SAMPLE_W-1:0] win_model[rew_pkg::WIN_LEN];
  int                           fill_model = 0;
  int                           held_score = 0;
  int                           col_model  = 0;
  logic [rew_pkg::THR_W-1:0]    thr_model  = rew_pkg::THR_RESET;

  initial begin
    for (int i = 0; i < rew_pkg::WIN_LEN; i++) win_model[i] = '0;
  end

  function automatic int draw_wait();
    return idle_on ? int'($urandom_range(0, 13)) : 0;
  endfunction

  task automatic push_result(input int s, input bit rend, input bit fend);
    det_result_t r;
    r.score     = s[rew_pkg::SCORE_W-1:0];
    r.detect    = (s > int'(thr_model));
    r.column    = col_model[rew_pkg::COL_W-1:0];
    r.row_end   = rend;
    r.frame_end = fend;
    due_results = {due_results, r};
    if (col_model < MAX_COLS - 1) col_model++;
  endtask

  task automatic advance_window(input logic [rew_pkg::SAMPLE_W-1:0] s, input logic lir,
                                input logic lof);
    bit rend;
    bit fend;
    int w;
    int r;
    int e;
    int rect;
    int flank;
    fend = lof;
    rend = lir | lof;
    if (fill_model >= rew_pkg::WIN_LEN && rend) begin
      // last bin of a full row: repeat the held score
      for (int i = 0; i < 3; i++) push_result(held_score, i == 2, fend && i == 2);
    end else begin
      for (int i = 0; i < rew_pkg::WIN_LEN - 1; i++) win_model[i] = win_model[i + 1];
      win_model[rew_pkg::WIN_LEN-1] = s;
      if (fill_model < rew_pkg::WIN_LEN) fill_model++;
      if (fill_model >= rew_pkg::WIN_LEN) begin
        w = 0;
        for (int i = 0; i < rew_pkg::WIN_LEN; i++) w += int'(win_model[i]);
        r = int'(win_model[2]) + int'(win_model[3]) + int'(win_model[4]);
        e = int'(win_model[4]) + int'(win_model[5]) + int'(win_model[6]);
        rect  = 7 * r - 3 * w;
        flank = 7 * e - 3 * w;
        if (flank < 0) flank = -flank;
        held_score = rect - flank;
        if (col_model == 0) begin
          // first full window: four padding copies
          for (int i = 0; i < 4; i++) push_result(held_score, 1'b0, 1'b0);
        end
        push_result(held_score, rend, fend && rend);
      end
    end
    if (rend) begin
      fill_model = 0;
      col_model  = 0;
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin : drive_bins
    bin_req_t nb;
    int       gap_left;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || samples_if.ready) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_bins.size() > 0) begin
        nb = pending_bins.pop_front();
        in_valid  <= 1'b1;
        in_sample <= nb.sample;
        in_lir    <= nb.last_in_row;
        in_lof    <= nb.last_of_frame;
        gap_left  = draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, fills the pipe and backs up the input
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && bins_taken >= HOLD_AT &&
                 pending_bins.size() >= HOLD_PENDING) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver
  always @(posedge clk) begin : drive_ready
    int stall_left;
    int n;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
    end else if (results_if.valid && results_if.ready) begin
      n = draw_wait();
      stall_left = n;
      out_ready <= (n == 0);
    end else if (stall_left > 0) begin
      out_ready <= (stall_left == 1);
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // prediction and compare
  always @(posedge clk) begin : score_check
    det_result_t want;
    if (!rst) begin
      if (samples_if.valid && samples_if.ready) begin
        advance_window(samples_if.sample, samples_if.last_in_row,
                       samples_if.last_of_frame);
        bins_taken <= bins_taken + 1;
      end
      if (results_if.valid && results_if.ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: score %0d column %0d", results_if.score,
                 results_if.column);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("score", {{10{want.score[rew_pkg::SCORE_W-1]}}, want.score},
                      {{10{results_if.score[rew_pkg::SCORE_W-1]}}, results_if.score});
          check_field("detect", {31'd0, want.detect}, {31'd0, results_if.detect});
          check_field("column", {22'd0, want.column}, {22'd0, results_if.column});
          check_field("row_end", {31'd0, want.row_end}, {31'd0, results_if.row_end});
          check_field("frame_end", {31'd0, want.frame_end},
                      {31'd0, results_if.frame_end});
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_rect_edge_window_detector: FAIL");
      $finish;
    end
  end

  task automatic push_bin(input logic [rew_pkg::SAMPLE_W-1:0] s, input logic lir,
                          input logic lof);
    bin_req_t b;
    b.sample        = s;
    b.last_in_row   = lir;
    b.last_of_frame = lof;
    pending_bins = {pending_bins, b};
    bins_queued++;
  endtask

  function automatic logic [rew_pkg::SAMPLE_W-1:0] bin_value(input row_shape_t shape,
                                                            input int idx, input int p0);
    case (shape)
      ROW_NOISE: return rew_pkg::SAMPLE_W'($urandom_range(0, 65535));
      ROW_PULSE: return (idx >= p0 && idx < p0 + 3)
                        ? rew_pkg::SAMPLE_W'($urandom_range(30000, 65535))
                        : rew_pkg::SAMPLE_W'($urandom_range(0, 2000));
      ROW_STEP:  return (idx >= p0) ? rew_pkg::SAMPLE_W'($urandom_range(40000, 65535))
                                    : rew_pkg::SAMPLE_W'($urandom_range(0, 500));
      default:   return rew_pkg::SAMPLE_W'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic queue_row(input int len, input row_shape_t shape);
    int  p0;
    int  mark;
    bit  lir;
    bit  lof;
    p0   = $urandom_range(0, len - 1);
    mark = $urandom_range(0, 5);
    lir  = (mark != 0);
    lof  = (mark <= 1);
    for (int i = 0; i < len - 1; i++) push_bin(bin_value(shape, i, p0), 1'b0, 1'b0);
    push_bin(bin_value(shape, len - 1, p0), lir, lof);
  endtask

  task automatic queue_random_rows(input int count);
    int target;
    int pick;
    int len;
    target = bins_queued + count;
    while (bins_queued < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) len = $urandom_range(1, 6);
      else if (pick == 1) len = rew_pkg::WIN_LEN;
      else len = $urandom_range(8, 24);
      queue_row(len, row_shape_t'($urandom_range(0, 3)));
    end
  endtask

  task automatic wait_drained();
    while (bins_taken != bins_queued || due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [rew_pkg::THR_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_valid <= 1'b0;
    thr_model = v;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset threshold; pulse row, exact-7 row ended by frame mark alone,
    // short row with both marks, rising edge row
    push_bin(16'h0000, 1'b0, 1'b0);
    push_bin(16'h0000, 1'b0, 1'b0);
    repeat (3) push_bin(16'hFFFF, 1'b0, 1'b0);
    push_bin(16'h0000, 1'b0, 1'b0);
    push_bin(16'h0000, 1'b0, 1'b0);
    push_bin(16'hFFFF, 1'b1, 1'b0);
    repeat (6) push_bin(16'hFFFF, 1'b0, 1'b0);
    push_bin(16'hFFFF, 1'b0, 1'b1);
    push_bin(16'hFFFF, 1'b0, 1'b0);
    push_bin(16'h0000, 1'b1, 1'b1);
    repeat (4) push_bin(16'h0000, 1'b0, 1'b0);
    repeat (3) push_bin(16'hFFFF, 1'b0, 1'b0);
    push_bin(16'h0001, 1'b1, 1'b1);
    wait_drained();

    write_threshold(rew_pkg::THR_W'(0));
    queue_random_rows(40);
    wait_drained();

    idle_on <= 1'b1;
    write_threshold(rew_pkg::THR_W'(THR_MAX));
    queue_random_rows(35);
    wait_drained();

    write_threshold(rew_pkg::THR_W'($urandom_range(0, 60000)));
    queue_random_rows(45);
    wait_drained();

    // back to back at the reset threshold
    idle_on <= 1'b0;
    write_threshold(rew_pkg::THR_RESET);
    queue_random_rows(20);
    wait_drained();

    idle_on <= 1'b1;
    write_threshold(rew_pkg::THR_W'($urandom_range(0, THR_MAX)));
    queue_random_rows(30);
    wait_drained();

    if (errors == 0) begin
      $display("tb_rect_edge_window_detector: PASS");
    end else begin
      $display("tb_rect_edge_window_detector: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rew_pkg.sv
rtl/rew_if.sv
rtl/rew_cell.sv
rtl/rew_score.sv
rtl/rew_emit.sv
rtl/rect_edge_window_detector.sv
rtl/rew_chk.sv
verif/tb_rect_edge_window_detector.sv
